// File: src/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console cell writer
// used by the front classifier, the command queue, the back end and the top level
// depends on nothing
package tcw_pkg;

  // input and result field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int REQ_W  = 2;

  // stream data widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 8'd1;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_E     = 8'h45;

  // command queue depth
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_PUT_ERR,
    OP_READ,
    OP_READ_ERR,
    OP_CLEAR,
    OP_NONE
  } tcw_op_t;

  typedef struct packed {
    tcw_op_t             op;
    logic [CHAR_W-1:0]   ch;
    logic [ATTR_W-1:0]   attr;
    logic                use_cursor;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
  } tcw_cmd_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_RESULT
  } tcw_state_t;

endpackage

// File: src/tcw_front.sv
// tcw_front: accepts input transfers and turns them into queue commands
// resolves the default attribute and the coordinate range check
// depends on tcw_pkg
module tcw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [tcw_pkg::REQ_W-1:0]         in_tuser,
  input  logic [tcw_pkg::ATTR_W-1:0]        default_attr,
  input  logic                              init_busy,
  input  logic                              q_full,
  output logic                              q_push,
  output tcw_pkg::tcw_cmd_t                 q_cmd
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] ch;
  logic [ATTR_W-1:0] attr;
  logic              use_cursor;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              bad;

  assign ch         = in_tdata[7:0];
  assign attr       = in_tdata[15:8];
  assign use_cursor = in_tdata[16];
  assign col        = in_tdata[23:17];
  assign row        = in_tdata[28:24];

  assign bad = !use_cursor && (({1'b0, col} >= (COL_W+1)'(COLS)) ||
                               ({1'b0, row} >= (ROW_W+1)'(ROWS)));

  // no intake while the store is being swept after reset
  assign in_tready = !q_full && !init_busy;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_cmd.ch         = ch;
    q_cmd.attr       = (attr == '0) ? default_attr : attr;
    q_cmd.use_cursor = use_cursor;
    q_cmd.col        = col;
    q_cmd.row        = row;
    case (in_tuser)
      REQ_PUT: begin
        if (bad)                q_cmd.op = OP_PUT_ERR;
        else if (ch == CHAR_NL) q_cmd.op = OP_NEWLINE;
        else if (ch == CHAR_BS) q_cmd.op = OP_BACKSPACE;
        else                    q_cmd.op = OP_PUT;
      end
      REQ_READ:  q_cmd.op = bad ? OP_READ_ERR : OP_READ;
      REQ_CLEAR: q_cmd.op = OP_CLEAR;
      default:   q_cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: src/tcw_cmd_fifo.sv
// tcw_cmd_fifo: short command queue between front and back end
// depends on tcw_pkg
module tcw_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcw_pkg::tcw_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output tcw_pkg::tcw_cmd_t pop_cmd,
  output logic              empty
);
  import tcw_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  tcw_cmd_t        slot_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full    = (count_r == CW'(QDEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/tcw_back.sv
// tcw_back: executes queued commands on the cell store and owns the cursor
// holds the cell memory, the sweep sequencer and the result register
// depends on tcw_pkg
module tcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [tcw_pkg::ATTR_W-1:0]     default_attr,
  input  logic [tcw_pkg::ATTR_W-1:0]     error_attr,
  input  logic                           cmd_valid,
  input  tcw_pkg::tcw_cmd_t              cmd,
  output logic                           cmd_pop,
  output logic                           init_busy,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tcw_pkg::*;

  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = ROWS * (1 << CW);
  localparam int CELL_W = CHAR_W + ATTR_W;

  tcw_state_t         state_r, state_nxt;
  logic [CW-1:0]      cur_col_r, cur_col_nxt;
  logic [RW-1:0]      cur_row_r, cur_row_nxt;
  logic [CW-1:0]      wk_col_r, wk_col_nxt;
  logic [RW-1:0]      wk_row_r, wk_row_nxt;
  logic               fill_init_r, fill_init_nxt;
  logic [CELL_W-1:0]  fill_data_r, fill_data_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic               res_err_r, res_err_nxt;
  logic               res_scr_r, res_scr_nxt;
  logic [CHAR_W-1:0]  res_char_r, res_char_nxt;
  logic [ATTR_W-1:0]  res_attr_r, res_attr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [CELL_W-1:0]  mem [DEPTH];
  logic [CELL_W-1:0]  rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic [AW-1:0]      mem_raddr;

  logic [CW-1:0]      tgt_col;
  logic [RW-1:0]      tgt_row;
  logic               tgt_col_last;
  logic               tgt_row_last;
  logic               wk_col_last;
  logic               wk_last;
  logic [CW-1:0]      wk_col_inc;
  logic [RW-1:0]      wk_row_inc;

  assign tgt_col      = cmd.use_cursor ? cur_col_r : cmd.col[CW-1:0];
  assign tgt_row      = cmd.use_cursor ? cur_row_r : cmd.row[RW-1:0];
  assign tgt_col_last = (tgt_col == CW'(COLS-1));
  assign tgt_row_last = (tgt_row == RW'(ROWS-1));
  assign wk_col_last  = (wk_col_r == CW'(COLS-1));
  assign wk_last      = wk_col_last && (wk_row_r == RW'(ROWS-1));
  assign wk_col_inc   = wk_col_last ? '0 : wk_col_r + 1'b1;
  assign wk_row_inc   = wk_col_last ? wk_row_r + 1'b1 : wk_row_r;

  assign init_busy  = (state_r == ST_FILL) && fill_init_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    wk_col_nxt    = wk_col_r;
    wk_row_nxt    = wk_row_r;
    fill_init_nxt = fill_init_r;
    fill_data_nxt = fill_data_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    res_err_nxt   = res_err_r;
    res_scr_nxt   = res_scr_r;
    res_char_nxt  = res_char_r;
    res_attr_nxt  = res_attr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = rd_data_r;
    mem_raddr     = {wk_row_r, wk_col_r};

    // delayed half of a scroll copy
    if (pend_r) begin
      mem_we = 1'b1;
    end

    case (state_r)
      ST_FILL: begin
        mem_we     = 1'b1;
        mem_waddr  = {wk_row_r, wk_col_r};
        mem_wdata  = fill_init_r ? '0 : fill_data_r;
        wk_col_nxt = wk_col_inc;
        wk_row_nxt = wk_row_inc;
        if (wk_last) begin
          state_nxt     = fill_init_r ? ST_IDLE : ST_RESULT;
          fill_init_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          res_err_nxt  = 1'b0;
          res_scr_nxt  = 1'b0;
          res_char_nxt = '0;
          res_attr_nxt = '0;
          state_nxt    = ST_RESULT;
          case (cmd.op)
            OP_PUT, OP_NEWLINE, OP_BACKSPACE: begin
              mem_waddr = {tgt_row, tgt_col};
              mem_wdata = {cmd.attr, (cmd.op == OP_BACKSPACE) ? CHAR_SPACE : cmd.ch};
              mem_we    = (cmd.op != OP_NEWLINE);
              if (cmd.op == OP_BACKSPACE) begin
                cur_col_nxt = tgt_col;
                cur_row_nxt = tgt_row;
              end else if (cmd.op == OP_PUT && !tgt_col_last) begin
                cur_col_nxt = tgt_col + 1'b1;
                cur_row_nxt = tgt_row;
              end else if (tgt_row_last) begin
                // moved past the bottom row (wrap or newline): scroll, cursor lands on bottom row
                cur_col_nxt = '0;
                cur_row_nxt = RW'(ROWS-1);
                res_scr_nxt = 1'b1;
                wk_col_nxt  = '0;
                wk_row_nxt  = RW'(1);
                state_nxt   = ST_SCROLL;
              end else begin
                cur_col_nxt = '0;
                cur_row_nxt = tgt_row + 1'b1;
              end
            end
            OP_PUT_ERR: begin
              mem_we      = 1'b1;
              mem_waddr   = {RW'(ROWS-1), CW'(COLS-1)};
              mem_wdata   = {error_attr, CHAR_E};
              res_err_nxt = 1'b1;
            end
            OP_READ: begin
              mem_raddr = {tgt_row, tgt_col};
              state_nxt = ST_READ;
            end
            OP_READ_ERR: begin
              res_err_nxt = 1'b1;
            end
            OP_CLEAR: begin
              cur_col_nxt   = '0;
              cur_row_nxt   = '0;
              fill_data_nxt = {default_attr, CHAR_SPACE};
              wk_col_nxt    = '0;
              wk_row_nxt    = '0;
              state_nxt     = ST_FILL;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end
      ST_READ: begin
        res_char_nxt = rd_data_r[CHAR_W-1:0];
        res_attr_nxt = rd_data_r[CELL_W-1:CHAR_W];
        state_nxt    = ST_RESULT;
      end
      ST_SCROLL: begin
        // read one row down, write back one row up next cycle
        pend_nxt      = 1'b1;
        pend_addr_nxt = {wk_row_r - 1'b1, wk_col_r};
        wk_col_nxt    = wk_col_inc;
        wk_row_nxt    = wk_row_inc;
        if (wk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        fill_data_nxt = '0;
        wk_col_nxt    = '0;
        wk_row_nxt    = RW'(ROWS-1);
        state_nxt     = ST_FILL;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[6:0]   = COL_W'(cur_col_r);
          out_data_nxt[11:7]  = ROW_W'(cur_row_r);
          out_data_nxt[12]    = res_err_r;
          out_data_nxt[13]    = res_scr_r;
          out_data_nxt[21:14] = res_char_r;
          out_data_nxt[29:22] = res_attr_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      wk_col_r    <= '0;
      wk_row_r    <= '0;
      fill_init_r <= 1'b1;
      fill_data_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      wk_col_r    <= wk_col_nxt;
      wk_row_r    <= wk_row_nxt;
      fill_init_r <= fill_init_nxt;
      fill_data_r <= fill_data_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    res_err_r   <= res_err_nxt;
    res_scr_r   <= res_scr_nxt;
    res_char_r  <= res_char_nxt;
    res_attr_r  <= res_attr_nxt;
    out_data_r  <= out_data_nxt;
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r <= CW'(COLS-1)) && (cur_row_r <= RW'(ROWS-1)))
    else $error("cursor outside the screen");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid && (state_r == ST_IDLE))
    else $error("command popped from empty queue");

  a_pend_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SCROLL) || (state_r == ST_DRAIN))
    else $error("scroll copy write outside scroll");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result raised outside result state");

  a_init_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !cmd_pop)
    else $error("command executed during reset sweep");

endmodule

// File: src/text_console_cell_writer_top.sv
// text_console_cell_writer_top: character-cell text console with scroll
// holds the configuration registers and joins front, command queue and back end
// depends on tcw_pkg, tcw_front, tcw_cmd_fifo, tcw_back
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------------
//  in_      | in        | in_tvalid/in_tready | tuser req_type, tdata char/attr/pos
//  out_     | out       | out_tvalid/tready   | tdata cursor, flags, cell read back
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// put and out-of-range requests go from idle straight to the result state, a read via the read state (memory read port)
// a scroll adds a copy walk, one cell a cycle, then a bottom row fill
// clear runs a fill walk over the store, one cell per cycle
// after reset a sweep zeroes the store; in_tready stays low until done
// the two-entry command queue and the result register let intake and output stall apart
module text_console_cell_writer_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input transfers
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, low bit up: char_code[7:0], attr[15:8], use_cursor[16], col[23:17],
  // row[28:24], zero[31:29]
  input  logic [tcw_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: req_type[1:0]
  input  logic [tcw_pkg::REQ_W-1:0]         in_tuser,
  // result transfers
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata, low bit up: cursor_col[6:0], cursor_row[11:7], coord_error[12],
  // scrolled[13], cell_char[21:14], cell_attr[29:22], zero[31:30]
  output logic [tcw_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] default_attr_r, default_attr_nxt;
  logic [ATTR_W-1:0] error_attr_r, error_attr_nxt;

  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  tcw_cmd_t q_in_cmd;
  tcw_cmd_t q_out_cmd;
  logic     init_busy;

  // config writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    default_attr_nxt = default_attr_r;
    error_attr_nxt   = error_attr_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DEFAULT_ATTR: default_attr_nxt = cfg_data;
        CFG_ERROR_ATTR:   error_attr_nxt   = cfg_data;
        default: begin
          default_attr_nxt = default_attr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= DEFAULT_ATTR_RST;
      error_attr_r   <= ERROR_ATTR_RST;
    end else begin
      default_attr_r <= default_attr_nxt;
      error_attr_r   <= error_attr_nxt;
    end
  end

  // front: decode request kind, range check, attribute default
  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .default_attr (default_attr_r),
    .init_busy    (init_busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_in_cmd)
  );

  // decoupling queue
  tcw_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .empty    (q_empty)
  );

  // back end: cell store, cursor, scroll and clear sweeps, result register
  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .default_attr (default_attr_r),
    .error_attr   (error_attr_r),
    .cmd_valid    (!q_empty),
    .cmd          (q_out_cmd),
    .cmd_pop      (q_pop),
    .init_busy    (init_busy),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule
